// ----- hdl/sdm_pkg.sv -----
// Shared types and constants of the spray dose monitor.
`timescale 1ns / 1ps
package sdm_pkg;

  // Divider operand widths: widest dividend is pulses * 2000000, widest divisor 15 * flow gap.
  localparam int unsigned DIV_NW = 37;
  localparam int unsigned DIV_DW = 36;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE     = 3'd7;

  // Dose status codes.
  localparam logic [2:0] ST_PAUSED  = 3'd0;
  localparam logic [2:0] ST_STOPPED = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_WITHIN  = 3'd4;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage

// ----- hdl/sdm_if.sv -----
// Valid/ready channels carrying one tick request and one monitor result.
`timescale 1ns / 1ps
interface sdm_in_if;
  logic               valid;
  logic               ready;
  logic               toggle_run;
  logic               accel_valid;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [7:0]         flow_pulses;
  logic [31:0]        now_ms;

  modport source (output valid, toggle_run, accel_valid, accel_x, accel_y, accel_z,
                  flow_pulses, now_ms, input ready);
  modport sink   (input valid, toggle_run, accel_valid, accel_x, accel_y, accel_z,
                  flow_pulses, now_ms, output ready);
endinterface

interface sdm_out_if;
  logic        valid;
  logic        ready;
  logic        running;
  logic [31:0] step_count;
  logic [11:0] speed_mm_s;
  logic [15:0] flow_ml_min;
  logic [15:0] dose_l_ha;
  logic [2:0]  dose_status;

  modport source (output valid, running, step_count, speed_mm_s, flow_ml_min, dose_l_ha,
                  dose_status, input ready);
  modport sink   (input valid, running, step_count, speed_mm_s, flow_ml_min, dose_l_ha,
                  dose_status, output ready);
endinterface

// ----- hdl/spray_dose_monitor_unit.sv -----
// Spray dose monitor: step and speed tracking, flow windowing, dose and status per tick.
// Sequence: a paused tick goes from idle to the output state; a running tick passes the
// squarer, step, decay, dose, classify and output states, plus a smoothing state after the
// speed division and a wait on the divider (one quotient bit per cycle over 37 bits) for
// each division it needs (speed, flow, dose). Requests are taken one at a time, in idle.
// Reset (asynchronous, active low) restores the default registers, sets running, clears state.
`timescale 1ns / 1ps
module spray_dose_monitor_unit import sdm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sdm_in_if.sink                in_s,
  sdm_out_if.source             out_m,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_STEP  = 4'd2;
  localparam logic [3:0] S_VDIV  = 4'd3;
  localparam logic [3:0] S_SDIV  = 4'd4;
  localparam logic [3:0] S_DECAY = 4'd5;
  localparam logic [3:0] S_FDIV  = 4'd6;
  localparam logic [3:0] S_DOSE  = 4'd7;
  localparam logic [3:0] S_DDIV  = 4'd8;
  localparam logic [3:0] S_CLASS = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  function automatic logic [15:0] sat16(input logic [DIV_NW-1:0] v);
    sat16 = (v[DIV_NW-1:16] != '0) ? 16'hFFFF : v[15:0];
  endfunction

  // Configuration registers.
  logic [10:0] cfg_step_len_q;
  logic [14:0] cfg_width_q;
  logic [13:0] cfg_target_q;
  logic [6:0]  cfg_tol_q;
  logic [31:0] cfg_thresh_q;
  logic [15:0] cfg_min_gap_q;
  logic [15:0] cfg_window_q;
  logic [15:0] cfg_idle_q;

  // Monitor state.
  logic [3:0]  state_q;
  logic        run_q;
  logic [31:0] steps_q;
  logic [31:0] last_step_q;
  logic [31:0] last_flow_q;
  logic [15:0] acc_q;
  logic [11:0] speed_q;
  logic [15:0] flow_q;
  logic [15:0] dose_q;
  logic [2:0]  stat_q;

  // Latched request and magnitude accumulation.
  logic               av_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [31:0]        now_q;
  logic [31:0]        mag_q;
  logic [1:0]         sq_cnt_q;

  // Weighted speed sum waiting to be divided by ten.
  logic [14:0] spd_num_q;

  // Result register.
  logic        out_valid_q;
  logic        out_running_q;
  logic [31:0] out_steps_q;
  logic [11:0] out_speed_q;
  logic [15:0] out_flow_q;
  logic [15:0] out_dose_q;
  logic [2:0]  out_status_q;

  div_req_t div_req_q;
  div_rsp_t div_rsp;

  sdm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // Combinational helpers for the sequencer.
  logic               run_n;
  logic [16:0]        acc_sum;
  logic signed [15:0] sq_sel;
  logic signed [31:0] sq_val;
  logic [31:0]        step_gap;
  logic [20:0]        step_num;
  logic [43:0]        gap_lim;
  logic [14:0]        spd_num;
  logic [30:0]        spd_prod;
  logic [11:0]        half_spd;
  logic [31:0]        flow_gap;
  logic [15:0]        win;
  logic [26:0]        dose_den;
  logic [22:0]        d100;
  logic [7:0]         lo_fac;
  logic [7:0]         hi_fac;
  logic [21:0]        lo_lim;
  logic [21:0]        hi_lim;

  assign run_n    = run_q ^ in_s.toggle_run;
  assign acc_sum  = {1'b0, acc_q} + 17'(in_s.flow_pulses);
  assign sq_val   = sq_sel * sq_sel;
  assign step_gap = now_q - last_step_q;
  assign step_num = 21'(cfg_step_len_q) * 21'd1000;
  assign gap_lim  = 44'(step_gap) * 44'd3000;
  assign spd_num  = 15'(speed_q) * 15'd4 + 15'(div_rsp.quo[11:0]) * 15'd6;
  // Reciprocal of ten: the product shifted right by 19 is exact for any 16-bit value.
  assign spd_prod = 31'(spd_num_q) * 31'd52429;
  assign half_spd = speed_q >> 1;
  assign flow_gap = now_q - last_flow_q;
  assign win      = (cfg_window_q == '0) ? 16'd1 : cfg_window_q;
  assign dose_den = 27'(speed_q) * 27'(cfg_width_q);
  assign d100     = 23'(dose_q) * 23'd100;
  assign lo_fac   = 8'd100 - {1'b0, cfg_tol_q};
  assign hi_fac   = 8'd100 + {1'b0, cfg_tol_q};
  assign lo_lim   = 22'(cfg_target_q) * 22'(lo_fac);
  assign hi_lim   = 22'(cfg_target_q) * 22'(hi_fac);

  // Axis picked for the shared squarer.
  always_comb begin
    case (sq_cnt_q)
      2'd0:    sq_sel = ax_q;
      2'd1:    sq_sel = ay_q;
      default: sq_sel = az_q;
    endcase
  end

  assign in_s.ready = (state_q == S_IDLE);

  // Configuration writes, sequencer and state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_step_len_q <= 11'd664;
      cfg_width_q    <= 15'd2000;
      cfg_target_q   <= 14'd150;
      cfg_tol_q      <= 7'd10;
      cfg_thresh_q   <= 32'd419430400;
      cfg_min_gap_q  <= 16'd400;
      cfg_window_q   <= 16'd200;
      cfg_idle_q     <= 16'd1500;
      state_q        <= S_IDLE;
      run_q          <= 1'b1;
      steps_q        <= '0;
      last_step_q    <= '0;
      last_flow_q    <= '0;
      acc_q          <= '0;
      speed_q        <= '0;
      flow_q         <= '0;
      dose_q         <= '0;
      stat_q         <= ST_PAUSED;
      av_q           <= 1'b0;
      ax_q           <= '0;
      ay_q           <= '0;
      az_q           <= '0;
      now_q          <= '0;
      mag_q          <= '0;
      sq_cnt_q       <= '0;
      spd_num_q      <= '0;
      div_req_q      <= '0;
      out_valid_q    <= 1'b0;
      out_running_q  <= 1'b0;
      out_steps_q    <= '0;
      out_speed_q    <= '0;
      out_flow_q     <= '0;
      out_dose_q     <= '0;
      out_status_q   <= ST_PAUSED;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_valid_q && out_m.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_LEN: cfg_step_len_q <= cfg_data_i[10:0];
          CFG_WIDTH:    cfg_width_q    <= cfg_data_i[14:0];
          CFG_TARGET:   cfg_target_q   <= cfg_data_i[13:0];
          CFG_TOL:      cfg_tol_q      <= cfg_data_i[6:0];
          CFG_THRESH:   cfg_thresh_q   <= cfg_data_i;
          CFG_MIN_GAP:  cfg_min_gap_q  <= cfg_data_i[15:0];
          CFG_WINDOW:   cfg_window_q   <= cfg_data_i[15:0];
          CFG_IDLE:     cfg_idle_q     <= cfg_data_i[15:0];
          default:      cfg_idle_q     <= cfg_idle_q;
        endcase
      end

      case (state_q)
        // Take a request, apply a run toggle and, while running, gather flow pulses.
        S_IDLE: begin
          if (in_s.valid) begin
            run_q    <= run_n;
            av_q     <= in_s.accel_valid;
            ax_q     <= in_s.accel_x;
            ay_q     <= in_s.accel_y;
            az_q     <= in_s.accel_z;
            now_q    <= in_s.now_ms;
            mag_q    <= '0;
            sq_cnt_q <= '0;
            if (run_n) begin
              acc_q   <= acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
              state_q <= S_SQ;
            end else begin
              stat_q  <= ST_PAUSED;
              state_q <= S_OUT;
            end
          end
        end
        // Squared magnitude, one axis a cycle.
        S_SQ: begin
          mag_q    <= mag_q + 32'(sq_val);
          sq_cnt_q <= sq_cnt_q + 2'd1;
          if (sq_cnt_q == 2'd2) begin
            state_q <= S_STEP;
          end
        end
        // Step detection; a plausible stride starts the speed division.
        S_STEP: begin
          state_q <= S_DECAY;
          if (av_q && mag_q > cfg_thresh_q && step_gap > 32'(cfg_min_gap_q)) begin
            steps_q     <= steps_q + 32'd1;
            last_step_q <= now_q;
            if (last_step_q != '0 && step_gap > 32'd100 && 44'(step_num) < gap_lim) begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= DIV_NW'(step_num);
              div_req_q.den   <= DIV_DW'(step_gap);
              state_q         <= S_VDIV;
            end
          end
        end
        // Smooth the new speed: 40 % old, 60 % new, over ten.
        S_VDIV: begin
          if (div_rsp.done) begin
            spd_num_q <= spd_num;
            state_q   <= S_SDIV;
          end
        end
        S_SDIV: begin
          speed_q <= spd_prod[30:19];
          state_q <= S_DECAY;
        end
        // Idle decay of speed and the flow window check.
        S_DECAY: begin
          if (step_gap > 32'(cfg_idle_q)) begin
            speed_q <= (half_spd < 12'd50) ? 12'd0 : half_spd;
          end
          state_q <= S_DOSE;
          if (flow_gap >= 32'(win)) begin
            acc_q       <= '0;
            last_flow_q <= now_q;
            if (32'(acc_q) * 32'd2000 > flow_gap) begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= DIV_NW'(acc_q) * DIV_NW'(2000000);
              div_req_q.den   <= DIV_DW'(flow_gap) * DIV_DW'(15);
              state_q         <= S_FDIV;
            end else begin
              flow_q <= '0;
            end
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            flow_q  <= sat16(div_rsp.quo);
            state_q <= S_DOSE;
          end
        end
        // Dose from flow over speed times width.
        S_DOSE: begin
          state_q <= S_CLASS;
          if (speed_q > 12'd100 && flow_q > 16'd50) begin
            if (dose_den == '0) begin
              dose_q <= 16'hFFFF;
            end else begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= DIV_NW'(flow_q) * DIV_NW'(600000);
              div_req_q.den   <= DIV_DW'(dose_den);
              state_q         <= S_DDIV;
            end
          end else begin
            dose_q <= '0;
          end
        end
        S_DDIV: begin
          if (div_rsp.done) begin
            dose_q  <= sat16(div_rsp.quo);
            state_q <= S_CLASS;
          end
        end
        // Classify against the tolerance band.
        S_CLASS: begin
          if (dose_q == '0) begin
            stat_q <= ST_STOPPED;
          end else if (cfg_tol_q < 7'd100 && 23'(lo_lim) > d100) begin
            stat_q <= ST_UNDER;
          end else if (d100 > 23'(hi_lim)) begin
            stat_q <= ST_OVER;
          end else begin
            stat_q <= ST_WITHIN;
          end
          state_q <= S_OUT;
        end
        // Hand the result over once the result register is free.
        S_OUT: begin
          if (!out_valid_q || out_m.ready) begin
            out_valid_q   <= 1'b1;
            out_running_q <= run_q;
            out_steps_q   <= steps_q;
            out_speed_q   <= speed_q;
            out_flow_q    <= flow_q;
            out_dose_q    <= dose_q;
            out_status_q  <= stat_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_m.valid       = out_valid_q;
  assign out_m.running     = out_running_q;
  assign out_m.step_count  = out_steps_q;
  assign out_m.speed_mm_s  = out_speed_q;
  assign out_m.flow_ml_min = out_flow_q;
  assign out_m.dose_l_ha   = out_dose_q;
  assign out_m.dose_status = out_status_q;

  // A quotient only arrives while the sequencer waits for one.
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_VDIV || state_q == S_FDIV || state_q == S_DDIV))
    else $error("quotient arrived outside a wait state");

  // The paused status goes with a paused result and only with it.
  a_status_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_status_q == ST_PAUSED) == !out_running_q))
    else $error("status disagrees with run flag");

  // Smoothed speed never leaves its range.
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= 12'd2999) else $error("speed out of range");

endmodule

// ----- hdl/sdm_div.sv -----
// Shared restoring divider producing one quotient bit per cycle while a division runs.
`timescale 1ns / 1ps
module sdm_div import sdm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try the divisor.
  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Iteration control and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= req_i.den;
        quo_q  <= req_i.num;
      end else if (busy_q) begin
        rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
        quo_q <= {quo_q[DIV_NW-2:0], fits};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  // A new division is only requested while the unit is free.
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");

  // Completion is flagged exactly when the iteration ends.
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q) else $error("divider ended without done");

  // The divisor holds for the whole iteration.
  a_den_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && $past(busy_q) |-> $stable(den_q)) else $error("divisor changed mid division");

endmodule
